// ===== rtl/core/pskt_pkg.sv =====
package pskt_pkg;

  // fixed field widths of the request and result beats
  localparam int unsigned KeyBytesW = 64;
  localparam int unsigned KeyLenW   = 4;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned STdataW   = 104;  // 100 payload bits padded to bytes
  localparam int unsigned MTdataW   = 32;
  localparam int unsigned StatusW   = 2;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SUM    = 1'b1
  } req_kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_UPDATED = 2'd0,
    ST_ADDED   = 2'd1,
    ST_FULL    = 2'd2,
    ST_SUM     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    req_kind_e             kind;
    logic [KeyBytesW-1:0]  key_bytes;
    logic [KeyLenW-1:0]    key_len;
    logic [ValueW-1:0]     item_value;
  } req_t;

  typedef struct packed {
    logic [ValueW-1:0] prefix_sum;
    status_e           status;
  } res_t;

endpackage

// ===== rtl/core/pskt_mem.sv =====
module pskt_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pskt_ctrl.sv =====
module pskt_ctrl #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned KeyChars     = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  pskt_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output pskt_pkg::res_t res_o
);

  localparam int unsigned IdxW   = $clog2(TableEntries);
  localparam int unsigned CntW   = $clog2(TableEntries + 1);
  localparam int unsigned KeyW   = 8 * KeyChars;
  localparam int unsigned LenW   = $clog2(KeyChars + 1);
  localparam int unsigned ValW   = pskt_pkg::ValueW;
  localparam int unsigned EntryW = KeyW + LenW + ValW;

  function automatic logic [KeyW-1:0] char_mask(input logic [LenW-1:0] len);
    logic [KeyW-1:0] m;
    m = '0;
    for (int c = 0; c < KeyChars; c++) begin
      if (c < int'(len)) begin
        m[KeyW-1-8*c -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  pskt_pkg::ctrl_state_e state_q, state_d;

  pskt_pkg::req_kind_e kind_q, kind_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [KeyW-1:0]     mask_q, mask_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [ValW-1:0]     val_q, val_d;

  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic [ValW-1:0]     acc_q, acc_d;
  pskt_pkg::status_e   status_q, status_d;
  logic [IdxW-1:0]     wr_idx_q, wr_idx_d;
  logic                wr_en_q, wr_en_d;

  logic                mem_we, mem_re;
  logic [EntryW-1:0]   mem_rdata;
  logic [KeyW-1:0]     e_key;
  logic [LenW-1:0]     e_len;
  logic [ValW-1:0]     e_val;
  logic                exact_hit, prefix_hit, scan_end;
  logic [LenW-1:0]     in_len;
  logic [KeyW-1:0]     in_mask;

  pskt_mem #(
    .Depth (TableEntries),
    .Width (EntryW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_q),
    .wdata_i ({key_q, len_q, val_q}),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign {e_key, e_len, e_val} = mem_rdata;

  // saturate length to the key size
  assign in_len  = (req_i.key_len > pskt_pkg::KeyLenW'(KeyChars)) ?
                   LenW'(KeyChars) : req_i.key_len[LenW-1:0];
  assign in_mask = char_mask(in_len);

  assign exact_hit  = pend_q && (e_len == len_q) && (e_key == key_q);
  assign prefix_hit = pend_q && (e_len >= len_q) && (((e_key ^ key_q) & mask_q) == '0);
  assign scan_end   = !pend_q && (rd_idx_q >= fill_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pskt_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = pskt_pkg::S_SCAN;
        end
      end
      pskt_pkg::S_SCAN: begin
        if ((kind_q == pskt_pkg::REQ_INSERT && exact_hit) || scan_end) begin
          state_d = pskt_pkg::S_DONE;
        end
      end
      pskt_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = pskt_pkg::S_IDLE;
        end
      end
      default: state_d = pskt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d      = kind_q;
    key_d       = key_q;
    mask_d      = mask_q;
    len_d       = len_q;
    val_d       = val_q;
    rd_idx_d    = rd_idx_q;
    fill_d      = fill_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    acc_d       = acc_q;
    status_d    = status_q;
    wr_idx_d    = wr_idx_q;
    wr_en_d     = wr_en_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o.prefix_sum = (kind_q == pskt_pkg::REQ_SUM) ? acc_q : '0;
    res_o.status     = status_q;
    unique case (state_q)
      pskt_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d   = req_i.kind;
          len_d    = in_len;
          mask_d   = in_mask;
          key_d    = req_i.key_bytes[pskt_pkg::KeyBytesW-1 -: KeyW] & in_mask;
          val_d    = req_i.item_value;
          rd_idx_d = '0;
          acc_d    = '0;
        end
      end
      pskt_pkg::S_SCAN: begin
        if (kind_q == pskt_pkg::REQ_INSERT && exact_hit) begin
          status_d = pskt_pkg::ST_UPDATED;
          wr_idx_d = pend_idx_q;
          wr_en_d  = 1'b1;
        end else begin
          // one read per cycle, the compare acts on the read data in the next cycle
          if (rd_idx_q < fill_q) begin
            mem_re     = 1'b1;
            pend_d     = 1'b1;
            pend_idx_d = rd_idx_q[IdxW-1:0];
            rd_idx_d   = rd_idx_q + CntW'(1);
          end
          if (kind_q == pskt_pkg::REQ_SUM && prefix_hit) begin
            acc_d = acc_q + e_val;
          end
          if (scan_end) begin
            if (kind_q == pskt_pkg::REQ_SUM) begin
              status_d = pskt_pkg::ST_SUM;
              wr_en_d  = 1'b0;
            end else if (fill_q == CntW'(TableEntries)) begin
              status_d = pskt_pkg::ST_FULL;
              wr_en_d  = 1'b0;
            end else begin
              status_d = pskt_pkg::ST_ADDED;
              wr_idx_d = fill_q[IdxW-1:0];
              wr_en_d  = 1'b1;
            end
          end
        end
      end
      pskt_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          mem_we = wr_en_q;
          if (status_q == pskt_pkg::ST_ADDED) begin
            fill_d = fill_q + CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pskt_pkg::S_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    mask_q     <= mask_d;
    len_q      <= len_d;
    val_q      <= val_d;
    rd_idx_q   <= rd_idx_d;
    pend_idx_q <= pend_idx_d;
    acc_q      <= acc_d;
    status_q   <= status_d;
    wr_idx_q   <= wr_idx_d;
    wr_en_q    <= wr_en_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TableEntries))
    else $error("fill count beyond table size");

  a_read_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (rd_idx_q < fill_q) && (state_q == pskt_pkg::S_SCAN))
    else $error("read of an unfilled slot");

  a_write_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == pskt_pkg::S_DONE) && res_ready_i)
    else $error("table write outside result handoff");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i && status_q == pskt_pkg::ST_ADDED)
    |=> fill_q == $past(fill_q) + CntW'(1))
    else $error("fill count did not advance on add");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("read and write overlap");

endmodule

// ===== rtl/core/prefix_sum_key_table_top.sv =====
// scan: an insert that hits an existing key ends the scan early
// handoff: one request is handled at a time; the next request is taken while a result beat
//   still waits in the output register
// reset: rst_ni is asynchronous active low and empties the table by zeroing the fill
//   count; no memory clearing pass is needed, so requests are taken right after reset
module prefix_sum_key_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned KEY_CHARS     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // key_bytes [63:0], key_len [67:64], item_value [99:68], zero pad [103:100]
  input  logic [pskt_pkg::STdataW-1:0]  s_axis_tdata_i,
  // req_type [0]
  input  logic [0:0]                    s_axis_tuser_i,
  // result side
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // prefix_sum [31:0]
  output logic [pskt_pkg::MTdataW-1:0]  m_axis_tdata_o,
  // status [1:0]
  output logic [pskt_pkg::StatusW-1:0]  m_axis_tuser_o
);

  pskt_pkg::req_t req;
  pskt_pkg::res_t res;
  pskt_pkg::res_t out_q;
  logic           res_valid, res_ready;
  logic           out_valid_q;

  // unpack the request beat
  assign req.kind       = pskt_pkg::req_kind_e'(s_axis_tuser_i[0]);
  assign req.key_bytes  = s_axis_tdata_i[63:0];
  assign req.key_len    = s_axis_tdata_i[67:64];
  assign req.item_value = s_axis_tdata_i[99:68];

  pskt_ctrl #(
    .TableEntries (TABLE_ENTRIES),
    .KeyChars     (KEY_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.prefix_sum;
  assign m_axis_tuser_o  = out_q.status;

  // a result beat held under backpressure must not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
    && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // inserts always report a zero sum
  a_insert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != pskt_pkg::ST_SUM) |-> m_axis_tdata_o == '0)
    else $error("nonzero sum on insert result");

  // result handoff only when the output register has room
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> m_axis_tvalid_o)
    else $error("result lost at output register");

endmodule

// ===== tb/tb_prefix_sum_key_table_top.sv =====
module tb_prefix_sum_key_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  // block configuration under test, kept at the defaults
  localparam int unsigned TableDepth    = 64;
  localparam int unsigned KeyChars      = 8;
  // worst request latency: full scan plus the fixed pipeline overhead
  localparam int unsigned ScanCycles    = TableDepth + 4;
  // stimulus shape
  localparam int unsigned PoolSize      = 80;    // more keys than slots, so the table fills
  localparam int unsigned RandomItems   = 1500;
  localparam int unsigned HoldOffAt     = 300;   // result count at which the sink holds off
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned DrainAt       = 800;   // random item at which the source waits
  // cycles without any beat before the run is declared hung
  localparam int unsigned StallLimit    = 4000;

  // mirror of the key table plus the queue of predicted result beats
  class key_table_scoreboard;
    logic [63:0]     stored_key   [TableDepth];
    logic [3:0]      stored_len   [TableDepth];
    logic [31:0]     stored_value [TableDepth];
    int unsigned     fill;
    pskt_pkg::res_t  expected_q [$];
    int unsigned     errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // characters 0..n-1 counted from the top byte down
    static function logic [63:0] prefix_mask(logic [3:0] n);
      if (n == 0) return 64'h0;
      return ~64'h0 << (64 - 8 * n);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(pskt_pkg::req_kind_e kind, logic [63:0] key_in,
                               logic [3:0] len_in, logic [31:0] value);
      logic [3:0]      eff_len;
      logic [63:0]     mask;
      logic [63:0]     key;
      pskt_pkg::res_t  exp;
      int              hit;
      eff_len = (len_in > KeyChars) ? 4'(KeyChars) : len_in;
      mask    = prefix_mask(eff_len);
      key     = key_in & mask;
      exp.prefix_sum = '0;
      hit     = -1;
      if (kind == pskt_pkg::REQ_SUM) begin
        exp.status = pskt_pkg::ST_SUM;
        for (int i = 0; i < fill; i++) begin
          if (stored_len[i] >= eff_len && ((stored_key[i] ^ key) & mask) == 64'h0) begin
            exp.prefix_sum = exp.prefix_sum + stored_value[i];
          end
        end
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (hit < 0 && stored_len[i] == eff_len && stored_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
          stored_value[hit] = value;
          exp.status = pskt_pkg::ST_UPDATED;
        end else if (fill >= TableDepth) begin
          exp.status = pskt_pkg::ST_FULL;
        end else begin
          stored_key[fill]   = key;
          stored_len[fill]   = eff_len;
          stored_value[fill] = value;
          fill++;
          exp.status = pskt_pkg::ST_ADDED;
        end
      end
      expected_q.push_back(exp);
    endfunction

    function void check_result(logic [31:0] sum, logic [1:0] st);
      pskt_pkg::res_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual sum %0d status %0d",
                 $time, $signed(sum), st);
        return;
      end
      exp = expected_q.pop_front();
      if (exp.prefix_sum !== sum) begin
        errors++;
        $display("%0t: prefix_sum expected %0d actual %0d",
                 $time, $signed(exp.prefix_sum), $signed(sum));
      end
      if (exp.status !== st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
      end
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request side, idle from time zero
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  // key_bytes [63:0], key_len [67:64], item_value [99:68], zero pad [103:100]
  logic [pskt_pkg::STdataW-1:0]  s_axis_tdata_i  = '0;
  // req_type [0]
  logic [0:0]                    s_axis_tuser_i  = '0;

  // result side
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // prefix_sum [31:0]
  logic [pskt_pkg::MTdataW-1:0]  m_axis_tdata_o;
  // status [1:0]
  logic [pskt_pkg::StatusW-1:0]  m_axis_tuser_o;

  key_table_scoreboard sb = new();

  // key pool for the random part; some keys share a prefix with an earlier one by construction
  logic [63:0] pool_key [PoolSize];
  logic [3:0]  pool_len [PoolSize];

  // source pacing state
  int unsigned send_burst_left = 0;

  prefix_sum_key_table_top #(
    .TABLE_ENTRIES (TableDepth),
    .KEY_CHARS     (KeyChars)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // offer one request beat, wait for the handshake, then maybe idle a while;
  // tvalid is only lowered when a gap follows, so back-to-back beats keep it high
  task automatic send_request(input pskt_pkg::req_kind_e kind, input logic [63:0] key,
                              input logic [3:0] len, input logic [31:0] value);
    int unsigned gap;
    int unsigned r;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, value, len, key};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(kind, key, len, value);
    if (send_burst_left > 0) begin
      send_burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // stretch of back-to-back beats
        send_burst_left = $urandom_range(10, 60);
        gap = 0;
      end else if (r < 85) begin
        gap = $urandom_range(0, 3);
      end else begin
        gap = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every predicted result beat has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // mostly random values, with the 32-bit extremes now and then
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // half the pool is derived from earlier keys so prefix sums hit several entries
  task automatic build_key_pool();
    int unsigned j;
    logic [3:0]  keep;
    logic [3:0]  nlen;
    logic [63:0] keep_mask;
    for (int i = 0; i < PoolSize; i++) begin
      nlen = 4'($urandom_range(0, KeyChars));
      if (i > 0 && $urandom_range(0, 1) == 1) begin
        j         = $urandom_range(0, i - 1);
        keep      = (pool_len[j] < nlen) ? pool_len[j] : nlen;
        keep_mask = key_table_scoreboard::prefix_mask(keep);
        pool_key[i] = ((pool_key[j] & keep_mask) | ({$urandom, $urandom} & ~keep_mask))
                      & key_table_scoreboard::prefix_mask(nlen);
      end else begin
        pool_key[i] = {$urandom, $urandom} & key_table_scoreboard::prefix_mask(nlen);
      end
      pool_len[i] = nlen;
    end
  endtask

  // one random request: pool inserts, pool prefix sums, or raw noise
  task automatic send_random_item();
    int unsigned r;
    int unsigned p;
    logic [3:0]  len;
    logic [63:0] junk;
    r    = $urandom_range(0, 99);
    p    = $urandom_range(0, PoolSize - 1);
    junk = {$urandom, $urandom};
    if (r < 50) begin
      // insert or update a pool key, junk past its length must be ignored
      len = pool_len[p];
      if (len == KeyChars && $urandom_range(0, 1) == 1) begin
        len = 4'($urandom_range(KeyChars + 1, 15));
      end
      send_request(pskt_pkg::REQ_INSERT,
                   pool_key[p] | (junk & ~key_table_scoreboard::prefix_mask(pool_len[p])),
                   len, pick_value());
    end else if (r < 85) begin
      // sum under a prefix of a pool key, possibly the empty prefix
      len = 4'($urandom_range(0, pool_len[p]));
      send_request(pskt_pkg::REQ_SUM,
                   (pool_key[p] & key_table_scoreboard::prefix_mask(len)) |
                   (junk & ~key_table_scoreboard::prefix_mask(len)),
                   (len == KeyChars && $urandom_range(0, 1) == 1) ?
                     4'($urandom_range(KeyChars + 1, 15)) : len,
                   $urandom);
    end else begin
      // raw noise across every field
      send_request(pskt_pkg::req_kind_e'($urandom_range(0, 1)), junk,
                   4'($urandom_range(0, 15)), $urandom);
    end
  endtask

  // result sink: checks each beat and paces tready, including one long hold-off
  initial begin
    int unsigned results_seen;
    int unsigned stall_left;
    int unsigned burst_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned r;
    results_seen = 0;
    stall_left   = 0;
    burst_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && results_seen >= HoldOffAt) begin
        // long hold-off while the source keeps offering, backs up into s_axis_tready_o
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        m_axis_tready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          stall_left = $urandom_range(10, 60);
          m_axis_tready_i <= 1'b0;
        end else if (r < 10) begin
          burst_left = $urandom_range(20, 100);
          m_axis_tready_i <= 1'b1;
        end else begin
          m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // hang detection: any beat on either side restarts the count
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, empty key, saturation, junk bytes, zero chars, wrap
    send_request(pskt_pkg::REQ_SUM,    64'hffff_ffff_ffff_ffff, 4'd0,  32'h1234_5678);
    send_request(pskt_pkg::REQ_INSERT, 64'hffff_ffff_ffff_ffff, 4'd0,  32'd5);   // empty key
    send_request(pskt_pkg::REQ_INSERT, 64'h0123_4567_89ab_cdef, 4'd0,  -32'sd7); // same key
    send_request(pskt_pkg::REQ_INSERT, 64'h4123_4567_89ab_cdef, 4'd1,  32'h7fff_ffff); // "A"
    send_request(pskt_pkg::REQ_INSERT, 64'h4142_0000_0000_0000, 4'd2,  32'h7fff_ffff); // "AB"
    send_request(pskt_pkg::REQ_SUM,    64'h41ff_ffff_ffff_ffff, 4'd1,  32'h0);   // wraps
    send_request(pskt_pkg::REQ_INSERT, 64'h00ff_ffff_ffff_ffff, 4'd1,  32'h8000_0000);
    send_request(pskt_pkg::REQ_INSERT, 64'h0000_ffff_ffff_ffff, 4'd2,  32'd1);   // two zeros
    send_request(pskt_pkg::REQ_SUM,    64'h0011_2233_4455_6677, 4'd1,  32'h0);
    send_request(pskt_pkg::REQ_INSERT, 64'hffff_ffff_ffff_ffff, 4'd8,  32'h8000_0000);
    send_request(pskt_pkg::REQ_INSERT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'd3);   // saturates
    send_request(pskt_pkg::REQ_INSERT, 64'h0000_0000_0000_0000, 4'd8,  32'hffff_ffff);
    send_request(pskt_pkg::REQ_SUM,    64'h0000_0000_0000_0000, 4'd12, 32'h0);
    send_request(pskt_pkg::REQ_SUM,    64'h5555_aaaa_5555_aaaa, 4'd0,  32'h0);   // every entry
    send_request(pskt_pkg::REQ_INSERT, 64'h4142_aaaa_5555_0000, 4'd2,  32'd9);   // "AB" update
    send_request(pskt_pkg::REQ_SUM,    64'h4142_1234_5678_9abc, 4'd2,  32'h0);
    send_request(pskt_pkg::REQ_INSERT, 64'hdead_beef_cafe_f00d, 4'd9,  32'h8000_0001);
    send_request(pskt_pkg::REQ_SUM,    64'hffff_ffff_ffff_ffff, 4'd15, 32'h0);
    send_request(pskt_pkg::REQ_SUM,    64'h5a00_0000_0000_0000, 4'd1,  32'h0);   // no match
    send_request(pskt_pkg::REQ_INSERT, 64'haa55_aa55_0000_0000, 4'd4,  32'h0);
    send_request(pskt_pkg::REQ_SUM,    64'h0000_0000_0000_0000, 4'd0,  32'h0);
    drain_results();

    // random: pool traffic with noise; the table fills partway through
    build_key_pool();
    for (int n = 0; n < RandomItems; n++) begin
      if (n == DrainAt) drain_results();
      send_random_item();
    end
    drain_results();

    // let any straggling beat show up before the verdict
    repeat (2 * ScanCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pskt_pkg.sv
rtl/core/pskt_mem.sv
rtl/core/pskt_ctrl.sv
rtl/core/prefix_sum_key_table_top.sv
tb/tb_prefix_sum_key_table_top.sv
